// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the record sorter.
// Standalone header; the files that check their logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ----- rtl/rsk_pkg.sv -----
// Shared types and constants of the record sorter.
// No dependencies; used by every module of the block.
package rsk_pkg;

    localparam int KEY_W        = 32;
    localparam int PAYLOAD_W    = 64;
    localparam int CAPACITY_DEF = 64;

    typedef struct packed {
        logic signed [KEY_W-1:0] sort_key;
        logic [PAYLOAD_W-1:0]    payload;
        logic                    last_record;
    } in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic [PAYLOAD_W-1:0]    out_payload;
        logic                    out_last;
        logic                    overflowed;
    } out_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAYLOAD_W-1:0]    payload;
    } rec_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } ctrl_t;

endpackage

// ----- rtl/record_sorter_by_key_top.sv -----
// Record sorter by key: systolic insertion sorter with an output register.
// Depends on rsk_pkg, rsk_chain, rsk_cell and assert_macros.svh.
//
// Usage:
//   Requests arrive on the s_ channel (s_valid, s_ready, s_data) as a key, a
//   payload and a last flag. While loading, one request is taken per cycle and
//   inserted into the cell chain in that same cycle, in stable ascending order.
//   A request marked last is inserted too, then the chain shifts its records
//   out from the head, one per cycle, to the m_ channel (m_valid, m_ready,
//   m_data). m_valid rises once the state register holds ST_EMIT and the first
//   record has been shifted into the output register.
//   The s_ channel is closed while a run is being shifted out and reopens as
//   soon as the final result sits in the output register.
//   Records that arrive with CAPACITY records held are dropped, and every
//   result of that run carries overflowed. The run still holds at least one
//   record.
//   When m_ready is low the output register holds its result and the chain
//   stops shifting; nothing is lost.
//   Reset empties the chain (count cleared), clears the overflow flag and the
//   output valid; no clearing pass is needed.
module record_sorter_by_key_top #(
    parameter int CAPACITY = rsk_pkg::CAPACITY_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rsk_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rsk_pkg::out_t m_data
);
    import rsk_pkg::*;

    `include "assert_macros.svh"

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(CAPACITY);
    localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    ctrl_t ctrl;
    rec_t  new_rec;
    rec_t  head_rec;
    logic  s_accept;

    assign s_ready  = (state_reg == ST_LOAD);
    assign s_accept = s_valid && s_ready;

    assign new_rec.key     = s_data.sort_key;
    assign new_rec.payload = s_data.payload;

    assign ctrl.insert = s_accept && (count_reg != COUNT_FULL);
    assign ctrl.shift  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    rsk_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .count    (count_reg),
        .new_rec  (new_rec),
        .head_rec (head_rec)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (s_accept) begin
            if (ctrl.insert) begin
                count_next = count_reg + COUNT_ONE;
            end else begin
                ovf_next = 1'b1;
            end
            if (s_data.last_record) begin
                state_next = ST_EMIT;
            end
        end

        if (ctrl.shift) begin
            m_valid_next            = 1'b1;
            m_data_next.out_key     = head_rec.key;
            m_data_next.out_payload = head_rec.payload;
            m_data_next.out_last    = (count_reg == COUNT_ONE);
            m_data_next.overflowed  = ovf_reg;
            count_next              = count_reg - COUNT_ONE;
            if (count_reg == COUNT_ONE) begin
                state_next = ST_LOAD;
                ovf_next   = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= COUNT_FULL)
    `ASSERT_IMPLY(a_emit_nonempty, aclk, aresetn, state_reg == ST_EMIT, count_reg != '0)
    `ASSERT_NEXT(a_last_after_run, aclk, aresetn, ctrl.shift && count_reg == COUNT_ONE,
        state_reg == ST_LOAD && m_data_reg.out_last)
    `ASSERT_NEXT(a_last_starts_emit, aclk, aresetn, s_accept && s_data.last_record,
        state_reg == ST_EMIT)
    `ASSERT_NEXT(a_drop_sets_flag, aclk, aresetn, s_accept && count_reg == COUNT_FULL,
        ovf_reg)

endmodule

// ----- rtl/rsk_cell.sv -----
// One cell of the sorting chain: holds a single record.
// Depends on rsk_pkg.
module rsk_cell (
    input  logic          aclk,
    input  rsk_pkg::ctrl_t ctrl,
    input  logic          valid,
    input  rsk_pkg::rec_t new_rec,
    input  rsk_pkg::rec_t left_rec,
    input  logic          left_greater,
    input  rsk_pkg::rec_t right_rec,
    output rsk_pkg::rec_t rec,
    output logic          greater
);
    import rsk_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;

    // A new key goes behind equal keys, so only a strictly larger stored key
    // or an empty cell moves aside. This keeps the sort stable.
    assign greater = !valid || (rec_reg.key > new_rec.key);

    always_comb begin
        rec_next = rec_reg;
        priority if (ctrl.shift) begin
            rec_next = right_rec;
        end else if (ctrl.insert && greater && !left_greater) begin
            rec_next = new_rec;
        end else if (ctrl.insert && greater) begin
            rec_next = left_rec;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

// ----- rtl/rsk_chain.sv -----
// Row of sorting cells kept in ascending key order, head at cell zero.
// Depends on rsk_pkg and rsk_cell.
module rsk_chain #(
    parameter  int CAPACITY = rsk_pkg::CAPACITY_DEF,
    localparam int COUNT_W  = $clog2(CAPACITY + 1)
) (
    input  logic               aclk,
    input  rsk_pkg::ctrl_t     ctrl,
    input  logic [COUNT_W-1:0] count,
    input  rsk_pkg::rec_t      new_rec,
    output rsk_pkg::rec_t      head_rec
);
    import rsk_pkg::*;

    rec_t [CAPACITY-1:0] recs;
    logic [CAPACITY-1:0] greater;
    logic [CAPACITY-1:0] valid;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        rec_t left_rec;
        rec_t right_rec;
        logic left_greater;

        // Cells fill from the head, so a cell is occupied below the count.
        assign valid[i] = COUNT_W'(i) < count;

        if (i == 0) begin : g_head
            assign left_rec     = new_rec;
            assign left_greater = 1'b0;
        end else begin : g_body
            assign left_rec     = recs[i-1];
            assign left_greater = greater[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_rec = new_rec;
        end else begin : g_inner
            assign right_rec = recs[i+1];
        end

        rsk_cell u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .valid        (valid[i]),
            .new_rec      (new_rec),
            .left_rec     (left_rec),
            .left_greater (left_greater),
            .right_rec    (right_rec),
            .rec          (recs[i]),
            .greater      (greater[i])
        );
    end

    assign head_rec = recs[0];

endmodule

// ----- verif/tb.sv -----
// Testbench for record_sorter_by_key_top: loads sets of keyed records and checks
// each sorted run against a stable ascending sort kept here, including store overflow.
// Depends on rsk_pkg and the record sorter RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsk_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 260;
    localparam int HOLD_AT      = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic signed [KEY_W-1:0] ONE_Q16 = 32'sh0001_0000;

    // Holds the records of the set being loaded and the results its sorted run must give.
    class record_sort_model;
        rec_t held[$];
        bit   overflow_seen;
        out_t expected_results[$];
        int   failures;
        int   results_checked;
        int   runs_closed;
        int   dropped;

        function void note_request(in_t req);
            rec_t r;
            if (held.size() < CAPACITY) begin
                r.key     = req.sort_key;
                r.payload = req.payload;
                held.push_back(r);
            end else begin
                overflow_seen = 1'b1;
                dropped++;
            end
            if (req.last_record) emit_sorted_run();
        endfunction

        // Stable insertion sort of the held set, then one expected result per record.
        function void emit_sorted_run();
            rec_t r;
            out_t o;
            int   i;
            int   j;
            for (i = 1; i < held.size(); i++) begin
                r = held[i];
                j = i;
                while (j > 0 && held[j-1].key > r.key) begin
                    held[j] = held[j-1];
                    j--;
                end
                held[j] = r;
            end
            for (i = 0; i < held.size(); i++) begin
                o.out_key     = held[i].key;
                o.out_payload = held[i].payload;
                o.out_last    = (i == held.size() - 1);
                o.overflowed  = overflow_seen;
                expected_results.push_back(o);
            end
            held.delete();
            overflow_seen = 1'b0;
            runs_closed++;
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_results.size() == 0) begin
                failures++;
                $display("%0t: result with none expected: key %0d payload %h",
                         $time, got.out_key, got.out_payload);
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (got.out_key !== want.out_key) begin
                failures++;
                $display("%0t: out_key mismatch: expected %0d, actual %0d",
                         $time, want.out_key, got.out_key);
            end
            if (got.out_payload !== want.out_payload) begin
                failures++;
                $display("%0t: out_payload mismatch: expected %h, actual %h",
                         $time, want.out_payload, got.out_payload);
            end
            if (got.out_last !== want.out_last) begin
                failures++;
                $display("%0t: out_last mismatch: expected %b, actual %b",
                         $time, want.out_last, got.out_last);
            end
            if (got.overflowed !== want.overflowed) begin
                failures++;
                $display("%0t: overflowed mismatch: expected %b, actual %b",
                         $time, want.overflowed, got.overflowed);
            end
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    record_sort_model board = new();
    int  cycle_count   = 0;
    int  requests_sent = 0;
    int  random_sent   = 0;
    bit  sender_steady = 1'b0;

    record_sorter_by_key_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Requests are noted before results are checked, so a run closed on this edge is seen.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) board.note_request(s_data);
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic offer_request(input logic signed [KEY_W-1:0] key,
                                 input logic [PAYLOAD_W-1:0] data, input bit last);
        int  gap;
        in_t req;
        gap = sender_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        req.sort_key    = key;
        req.payload     = data;
        req.last_record = last;
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    // Drops s_valid and lets the monitor note the last accepted request before waiting for the drain.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.expected_results.size() != 0) @(posedge aclk);
    endtask

    // A quarter of the keys come from a small pool so that equal keys are common.
    function automatic logic signed [KEY_W-1:0] draw_key();
        int pick;
        if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 4);
            return (pick - 2) * ONE_Q16;
        end
        return $urandom;
    endfunction

    task automatic send_set(input int size);
        int i;
        for (i = 0; i < size; i++) begin
            offer_request(draw_key(), {$urandom, $urandom}, i == size - 1);
            random_sent++;
        end
    endtask

    initial begin : result_sink
        int stall;
        int taken;
        bit steady;
        taken  = 0;
        steady = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 16 == 0) steady = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AT) begin
                // Long hold-off while the sender keeps offering requests.
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = steady ? 0 : $urandom_range(0, 5);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin : request_source
        int set_index;
        int size;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A run of one record.
        offer_request('0, '0, 1'b1);
        // Extreme keys and payloads.
        offer_request(32'sh7FFF_FFFF, '1, 1'b0);
        offer_request(32'sh8000_0000, '0, 1'b0);
        offer_request(-32'sd1, 64'h5555_5555_5555_5555, 1'b0);
        offer_request(32'sd1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        offer_request(ONE_Q16, 64'h0123_4567_89AB_CDEF, 1'b1);
        // Equal keys must come out in load order.
        offer_request(5 * ONE_Q16, 64'd1, 1'b0);
        offer_request(5 * ONE_Q16, 64'd2, 1'b0);
        offer_request(-3 * ONE_Q16, 64'd3, 1'b0);
        offer_request(5 * ONE_Q16, 64'd4, 1'b0);
        offer_request(-3 * ONE_Q16, 64'd5, 1'b1);

        // Mostly small sets; one exactly fills the store, one overflows it so the records past CAPACITY are dropped.
        set_index = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (set_index == 12) hold_until_drained();
            sender_steady = ($urandom_range(0, 3) == 0);
            if (set_index == 3) begin
                size = CAPACITY;
            end else if (set_index == 8) begin
                size = CAPACITY + $urandom_range(1, 3);
            end else begin
                size = $urandom_range(1, 8);
            end
            send_set(size);
            set_index++;
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d requests in %0d sorted runs, %0d results checked, %0d records dropped",
                 requests_sent, board.runs_closed, board.results_checked, board.dropped);
        if (board.failures == 0 && board.expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            if (board.expected_results.size() != 0) begin
                $display("%0t: %0d expected results never arrived",
                         $time, board.expected_results.size());
            end
            $display("%0d mismatches", board.failures);
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rsk_pkg.sv
rtl/rsk_cell.sv
rtl/rsk_chain.sv
rtl/record_sorter_by_key_top.sv
verif/tb.sv
